// ----- design/kcrm_pkg.sv -----
// Shared types and constants for the keypress code and rate monitor.
package kcrm_pkg;

  // Field and register widths
  localparam int CODE_W   = 40;
  localparam int WINDOW_W = 16;
  localparam int THRESH_W = 8;
  localparam int TIME_W   = 32;
  localparam int DIGIT_W  = 4;
  localparam int CODE_MAX_DIGITS = CODE_W / DIGIT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CODE_W;

  // Register defaults
  localparam logic [CODE_W-1:0]   CODE_RESET   = 40'd233624142849;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd25;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESHUFFLE_COUNT = 2'd2;

  // System modes
  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_ADMIN = 2'd1;

  typedef struct packed {
    logic [DIGIT_W-1:0] button_id;
    logic               pressed;
    logic [TIME_W-1:0]  time_ms;
    logic [1:0]         mode;
  } in_item_t;

  typedef struct packed {
    logic unlock;
    logic reshuffle;
    logic overspeed;
  } out_item_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic record;
    logic last_digit;
    logic slot_free;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_FINISH
  } ctl_state_t;

endpackage

// ----- design/kcrm_ctrl.sv -----
// Sequencer: accept a request, walk the code digits for a recorded press, then post the result.
module kcrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kcrm_pkg::dp_stat_t stat,
  output kcrm_pkg::ctl_cmd_t cmd
);
  import kcrm_pkg::*;

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.record ? ST_COMPARE : ST_FINISH;
        end
      end
      ST_COMPARE: begin
        if (stat.last_digit) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_COMPARE: cmd.step   = 1'b1;
      ST_FINISH:  cmd.finish = stat.slot_free;
      default:    cmd        = '0;
    endcase
  end

endmodule

// ----- design/kcrm_dpath.sv -----
// Datapath: config registers, press and time histories, counters and result register.
module kcrm_dpath #(
  parameter int CODE_DIGITS   = 10,
  parameter int BURST_PRESSES = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kcrm_pkg::in_item_t                 in_data,
  input  logic                               cfg_we,
  input  logic [kcrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kcrm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  kcrm_pkg::ctl_cmd_t                 cmd,
  output kcrm_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output kcrm_pkg::out_item_t                out_data
);
  import kcrm_pkg::*;

  localparam int IDX_W   = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int PCNT_W  = $clog2(CODE_DIGITS + 1);
  localparam int TCNT_W  = $clog2(BURST_PRESSES + 1);
  localparam int KEEP    = (CODE_DIGITS < CODE_MAX_DIGITS) ? CODE_DIGITS : CODE_MAX_DIGITS;
  localparam logic [CODE_W-1:0] CODE_MASK =
    (KEEP == CODE_MAX_DIGITS) ? {CODE_W{1'b1}} :
    ((CODE_W'(1) << (DIGIT_W * KEEP)) - CODE_W'(1));
  localparam logic [PCNT_W-1:0] PRESS_FULL = PCNT_W'(CODE_DIGITS);
  localparam logic [TCNT_W-1:0] TIME_FULL  = TCNT_W'(BURST_PRESSES);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(CODE_DIGITS - 1);

  // Configuration registers
  logic [CODE_W-1:0]   code_r;
  logic [WINDOW_W-1:0] window_r;
  logic [THRESH_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= CODE_RESET & CODE_MASK;
      window_r <= WINDOW_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_UNLOCK_CODE)     code_r   <= cfg_data & CODE_MASK;
      if (cfg_index == CFG_BURST_WINDOW)    window_r <= cfg_data[WINDOW_W-1:0];
      if (cfg_index == CFG_RESHUFFLE_COUNT) thresh_r <= cfg_data[THRESH_W-1:0];
    end
  end

  // Code digits; digits past the register width expect zero
  logic [DIGIT_W-1:0] code_dig [16];
  for (genvar k = 0; k < 16; k++) begin : g_dig
    if (k < CODE_MAX_DIGITS) begin : g_reg
      assign code_dig[k] = code_r[DIGIT_W*k +: DIGIT_W];
    end else begin : g_zero
      assign code_dig[k] = '0;
    end
  end

  // Item context latched at capture
  logic rec_r, run_r;
  logic rec_now;
  assign rec_now = in_data.pressed && (in_data.mode != MODE_ADMIN);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rec_r <= rec_now;
      run_r <= (in_data.mode == MODE_RUN);
    end
  end

  // Press and time histories, newest in slot 0
  logic [DIGIT_W-1:0] press_hist_r [CODE_DIGITS];
  logic [TIME_W-1:0]  time_hist_r  [BURST_PRESSES];
  logic [PCNT_W-1:0]  press_cnt_r;
  logic [TCNT_W-1:0]  time_cnt_r;
  logic               shift_in;
  logic               unlock_now;

  assign shift_in = cmd.capture && rec_now;

  always_ff @(posedge clk) begin
    if (shift_in) begin
      press_hist_r[0] <= in_data.button_id;
      time_hist_r[0]  <= in_data.time_ms;
      for (int k = 1; k < CODE_DIGITS; k++) press_hist_r[k] <= press_hist_r[k-1];
      for (int k = 1; k < BURST_PRESSES; k++) time_hist_r[k] <= time_hist_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_cnt_r <= '0;
      time_cnt_r  <= '0;
    end else if (cmd.finish && unlock_now) begin
      press_cnt_r <= '0;
      time_cnt_r  <= '0;
    end else if (shift_in) begin
      if (press_cnt_r != PRESS_FULL) press_cnt_r <= press_cnt_r + PCNT_W'(1);
      if (time_cnt_r != TIME_FULL)   time_cnt_r  <= time_cnt_r + TCNT_W'(1);
    end
  end

  // Digit walk: oldest held press against digit 0 first
  logic [IDX_W-1:0]   idx_r;
  logic               mismatch_r;
  logic [IDX_W-1:0]   hist_sel;
  logic [DIGIT_W-1:0] want;

  assign hist_sel = IDX_LAST - idx_r;
  assign want     = code_dig[4'(idx_r)];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r      <= '0;
      mismatch_r <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (press_hist_r[hist_sel] != want) mismatch_r <= 1'b1;
    end
  end

  // Decision
  logic [THRESH_W-1:0] cnt_r, cnt_inc;
  logic [TIME_W-1:0]   span;
  logic                resh_now, over_now;

  assign cnt_inc    = cnt_r + THRESH_W'(1);
  assign span       = time_hist_r[0] - time_hist_r[BURST_PRESSES-1];
  assign unlock_now = rec_r && (press_cnt_r == PRESS_FULL) && !mismatch_r;
  assign resh_now   = rec_r && !unlock_now && run_r && (cnt_inc >= thresh_r);
  assign over_now   = rec_r && !unlock_now && run_r && (time_cnt_r == TIME_FULL) &&
                      (span <= TIME_W'(window_r));

  // Press counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.finish && rec_r && !unlock_now) begin
      cnt_r <= (resh_now || over_now) ? '0 : cnt_inc;
    end
  end

  // Result register
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.unlock    <= unlock_now;
      out_data_r.reshuffle <= resh_now;
      out_data_r.overspeed <= over_now;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.record     = rec_now;
  assign stat.last_digit = (idx_r == IDX_LAST);
  assign stat.slot_free  = !out_valid_r || out_ready;

endmodule

// ----- design/keypress_code_and_rate_monitor.sv -----
// Each request is captured; for a recorded press the code digits are then walked before the
// finish, while an ignored event goes straight to it. Throughput: one request at a time, the
// next taken once the last is finished; the digit walk compares one code digit per cycle. A
// waiting result does not block the next request from being taken, only its finish.
// Reset (rst_n, synchronous): histories and press counter empty, registers at defaults,
// no result pending. The configuration port is always ready.
module keypress_code_and_rate_monitor #(
  parameter int CODE_DIGITS   = 10,
  parameter int BURST_PRESSES = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kcrm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output kcrm_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kcrm_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  kcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kcrm_dpath #(
    .CODE_DIGITS   (CODE_DIGITS),
    .BURST_PRESSES (BURST_PRESSES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
